// ===== hdl/fpgs_pkg.sv =====
// Types, breakpoints, rule tables and constants shared by the fuzzy P/D gain scheduler.
`default_nettype none

package fpgs_pkg;

  // One input item and one result item
  typedef struct packed {
    logic signed [15:0] error;
    logic signed [15:0] error_change;
  } sample_t;

  typedef struct packed {
    logic [5:0] prop_gain_hundredths;
    logic [5:0] deriv_gain_hundredths;
  } gain_t;

  // Pipeline depth: two fuzzify, two inference, three divider stages
  localparam int NUM_STAGES = 7;

  typedef logic signed [15:0] bp_t;
  typedef logic [2:0]         seg_t;
  typedef logic [6:0]         mu_t;
  typedef logic [2:0]         rule_t;
  typedef logic [5:0]         outv_t;

  // Breakpoint sets
  localparam bp_t ERR_BP [7] = '{-16'sd180, -16'sd110, -16'sd50, 16'sd0,
                                 16'sd50, 16'sd110, 16'sd180};
  localparam bp_t CHG_BP [7] = '{-16'sd12, -16'sd8, -16'sd4, 16'sd0,
                                 16'sd4, 16'sd8, 16'sd12};

  // Full membership, in percent
  localparam mu_t MU_FULL = 7'd100;

  // floor(n/7) = (n * 2341) >> 14 for n < 5000; floor(n/3) = (n * 171) >> 9 for n < 512
  localparam logic [11:0] RECIP_7       = 12'd2341;
  localparam int          RECIP_7_SHIFT = 14;
  localparam logic [7:0]  RECIP_3       = 8'd171;
  localparam int          RECIP_3_SHIFT = 9;

  // Error-change segments are all 4 wide: 100*d/4 = 25*d
  localparam mu_t CHG_SCALE = 7'd25;

  // Rule tables, row = error segment, column = error-change segment
  localparam rule_t P_RULE [7][7] = '{
    '{3'd6, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4},
    '{3'd5, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1},
    '{3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
    '{3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2},
    '{3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2},
    '{3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5},
    '{3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6}};

  localparam rule_t D_RULE [7][7] = '{
    '{3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3},
    '{3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3},
    '{3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3},
    '{3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1},
    '{3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2},
    '{3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3},
    '{3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2}};

  // Output singletons
  localparam outv_t P_OUT [7] = '{6'd0, 6'd10, 6'd20, 6'd30, 6'd40, 6'd50, 6'd60};
  localparam outv_t D_OUT [7] = '{6'd10, 6'd20, 6'd30, 6'd40, 6'd0, 6'd0, 6'd0};

  // Segments and memberships of both inputs
  typedef struct packed {
    seg_t seg_e;
    seg_t seg_c;
    mu_t  pe0;
    mu_t  pe1;
    mu_t  pc0;
    mu_t  pc1;
  } fuzz_t;

  // Centroid numerator and weight sum (sum <= 200, numerator <= 12000)
  typedef struct packed {
    logic [13:0] num;
    logic [7:0]  den;
  } ratio_t;

endpackage

`default_nettype wire

// ===== hdl/fpgs_fuzzify.sv =====
// Two-stage fuzzifier: segment search, then percent membership of both inputs.
`default_nettype none

module fpgs_fuzzify
  import fpgs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic [1:0] en,
  input  wire sample_t sample,
  output fuzz_t        fuzz
);

  // Stage 1: segment, distance to upper breakpoint, clamps
  seg_t        seg_e_c, seg_c_c;
  logic [15:0] diff_e, diff_c;

  always_comb begin
    seg_e_c = '0;
    seg_c_c = '0;
    for (int k = 1; k < 6; k++) begin
      if (sample.error > ERR_BP[k]) seg_e_c = seg_e_c + 3'd1;
      if (sample.error_change > CHG_BP[k]) seg_c_c = seg_c_c + 3'd1;
    end
  end

  assign diff_e = ERR_BP[seg_e_c + 3'd1] - sample.error;
  assign diff_c = CHG_BP[seg_c_c + 3'd1] - sample.error_change;

  seg_t       seg_e, seg_c;
  logic [6:0] de;
  logic [1:0] dc;
  logic       lo_e, hi_e, lo_c, hi_c;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      seg_e <= seg_e_c;
      seg_c <= seg_c_c;
      de    <= diff_e[6:0];
      dc    <= diff_c[1:0];
      lo_e  <= (sample.error <= ERR_BP[0]);
      hi_e  <= (sample.error >= ERR_BP[6]);
      lo_c  <= (sample.error_change <= CHG_BP[0]);
      hi_c  <= (sample.error_change >= CHG_BP[6]);
    end
  end

  // Stage 2: floor(100*d/width) by constant reciprocals, or by doubling for width 50
  logic [21:0] m70;
  logic [15:0] m60;
  mu_t         mu_e_seg, mu_e, mu_c;

  assign m70 = (22'({de, 3'b000}) + 22'({de, 1'b0})) * 22'(RECIP_7);
  assign m60 = (16'({de, 2'b00}) + 16'(de)) * 16'(RECIP_3);

  always_comb begin
    case (seg_e) inside
      3'd0, 3'd5: mu_e_seg = 7'(m70 >> RECIP_7_SHIFT);
      3'd1, 3'd4: mu_e_seg = 7'(m60 >> RECIP_3_SHIFT);
      default:    mu_e_seg = {de[5:0], 1'b0};
    endcase
    if (lo_e)      mu_e = MU_FULL;
    else if (hi_e) mu_e = '0;
    else           mu_e = mu_e_seg;
    if (lo_c)      mu_c = MU_FULL;
    else if (hi_c) mu_c = '0;
    else           mu_c = 7'(7'(dc) * CHG_SCALE);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fuzz.seg_e <= seg_e;
      fuzz.seg_c <= seg_c;
      fuzz.pe0   <= mu_e;
      fuzz.pe1   <= MU_FULL - mu_e;
      fuzz.pc0   <= mu_c;
      fuzz.pc1   <= MU_FULL - mu_c;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fpgs_infer.sv =====
// Two-stage rule evaluation: cell weights with pruning, then centroid sums for both gains.
`default_nettype none

module fpgs_infer
  import fpgs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic [1:0] en,
  input  wire fuzz_t  fuzz,
  output ratio_t      ratio_p,
  output ratio_t      ratio_d
);

  typedef logic [3:0][2:0] rules_t;
  typedef logic [3:0][6:0] weights_t;

  function automatic mu_t min_mu(input mu_t a, input mu_t b);
    return (a <= b) ? a : b;
  endfunction

  // Of cells sharing a rule value, keep only the larger weight (pairs in fixed order)
  function automatic weights_t prune(input rules_t r, input weights_t w_in);
    weights_t w;
    w = w_in;
    for (int i = 0; i < 4; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        if (r[i] == r[j]) begin
          if (w[i] > w[j]) w[j] = '0;
          else             w[i] = '0;
        end
      end
    end
    return w;
  endfunction

  // Stage 3: the four neighbouring cells
  seg_t     row1, col1;
  rules_t   rp_c, rd_c;
  weights_t w_raw;

  assign row1 = fuzz.seg_e + 3'd1;
  assign col1 = fuzz.seg_c + 3'd1;

  always_comb begin
    rp_c[0] = P_RULE[fuzz.seg_e][fuzz.seg_c];
    rp_c[1] = P_RULE[row1][fuzz.seg_c];
    rp_c[2] = P_RULE[fuzz.seg_e][col1];
    rp_c[3] = P_RULE[row1][col1];
    rd_c[0] = D_RULE[fuzz.seg_e][fuzz.seg_c];
    rd_c[1] = D_RULE[row1][fuzz.seg_c];
    rd_c[2] = D_RULE[fuzz.seg_e][col1];
    rd_c[3] = D_RULE[row1][col1];
    w_raw[0] = min_mu(fuzz.pe0, fuzz.pc0);
    w_raw[1] = min_mu(fuzz.pe1, fuzz.pc0);
    w_raw[2] = min_mu(fuzz.pe0, fuzz.pc1);
    w_raw[3] = min_mu(fuzz.pe1, fuzz.pc1);
  end

  rules_t   rp, rd;
  weights_t wp, wd;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rp <= rp_c;
      rd <= rd_c;
      wp <= prune(rp_c, w_raw);
      wd <= prune(rd_c, w_raw);
    end
  end

  // Stage 4: weighted sums
  logic [14:0] num_p, num_d;
  logic [8:0]  den_p, den_d;

  always_comb begin
    num_p = '0;
    num_d = '0;
    den_p = '0;
    den_d = '0;
    for (int i = 0; i < 4; i++) begin
      num_p = num_p + 15'(13'(P_OUT[rp[i]]) * 13'(wp[i]));
      num_d = num_d + 15'(13'(D_OUT[rd[i]]) * 13'(wd[i]));
      den_p = den_p + 9'(wp[i]);
      den_d = den_d + 9'(wd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ratio_p.num <= num_p[13:0];
      ratio_p.den <= den_p[7:0];
      ratio_d.num <= num_d[13:0];
      ratio_d.den <= den_d[7:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/fpgs_divider.sv =====
// Three-stage restoring divider, two quotient bits per stage, six-bit quotient.
`default_nettype none

module fpgs_divider
  import fpgs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic [2:0] en,
  input  wire ratio_t ratio,
  output logic [5:0]  quot
);

  logic [13:0] rem_in [3];
  logic [7:0]  den_in [3];
  logic [5:0]  q_in   [3];
  logic [13:0] rem_r  [3];
  logic [7:0]  den_r  [3];
  logic [5:0]  q_r    [3];

  assign rem_in[0] = ratio.num;
  assign den_in[0] = ratio.den;
  assign q_in[0]   = '0;

  for (genvar s = 0; s < 3; s++) begin : g_stage
    logic [13:0] rem_c;
    logic [5:0]  q_c;

    if (s > 0) begin : g_link
      assign rem_in[s] = rem_r[s-1];
      assign den_in[s] = den_r[s-1];
      assign q_in[s]   = q_r[s-1];
    end

    // Quotient bits 5-2s and 4-2s
    always_comb begin
      logic [13:0] dsh;
      rem_c = rem_in[s];
      q_c   = q_in[s];
      for (int t = 0; t < 2; t++) begin
        dsh = 14'(den_in[s]) << (5 - 2 * s - t);
        if (rem_c >= dsh) begin
          rem_c = rem_c - dsh;
          q_c[5 - 2 * s - t] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= rem_c;
        den_r[s] <= den_in[s];
        q_r[s]   <= q_c;
      end
    end
  end

  // Empty weight sum gives a gain of zero
  assign quot = (den_r[2] == '0) ? '0 : q_r[2];

endmodule

`default_nettype wire

// ===== hdl/fuzzy_pd_gain_scheduler_core.sv =====
// Top level of the fuzzy P/D gain scheduler: seven-stage pipeline with stage valid bits.
// Depth: 7 register stages; gain_valid rises when an accepted item reaches the last one.
// Throughput: one item per cycle while gain_ready holds; the divider is split over three stages, two bits each.
// A stalled output holds its item; empty upstream stages still fill behind it.
// Reset (rst, synchronous) clears the stage valid bits only; data registers are not reset.
`default_nettype none

module fuzzy_pd_gain_scheduler_core
  import fpgs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    sample_valid,
  output logic         sample_ready,
  input  wire sample_t sample,
  output logic         gain_valid,
  input  wire logic    gain_ready,
  output gain_t        gain
);

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES:0]   adv;

  // A stage loads when it is empty or its successor loads
  always_comb begin
    adv[NUM_STAGES] = gain_ready;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      adv[i] = !valid[i] || adv[i+1];
    end
  end

  logic [NUM_STAGES-1:0] valid_next;

  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (!adv[i])     valid_next[i] = valid[i];
      else if (i == 0) valid_next[i] = sample_valid;
      else             valid_next[i] = valid[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign sample_ready = adv[0];
  assign gain_valid   = valid[NUM_STAGES-1];

  // Datapath
  fuzz_t      fuzz;
  ratio_t     ratio_p, ratio_d;
  logic [5:0] quot_p, quot_d;

  fpgs_fuzzify u_fuzzify (
    .clk    (clk),
    .en     (adv[1:0]),
    .sample (sample),
    .fuzz   (fuzz)
  );

  fpgs_infer u_infer (
    .clk     (clk),
    .en      (adv[3:2]),
    .fuzz    (fuzz),
    .ratio_p (ratio_p),
    .ratio_d (ratio_d)
  );

  fpgs_divider u_div_p (
    .clk   (clk),
    .en    (adv[6:4]),
    .ratio (ratio_p),
    .quot  (quot_p)
  );

  fpgs_divider u_div_d (
    .clk   (clk),
    .en    (adv[6:4]),
    .ratio (ratio_d),
    .quot  (quot_d)
  );

  assign gain.prop_gain_hundredths  = quot_p;
  assign gain.deriv_gain_hundredths = quot_d;

endmodule

`default_nettype wire

// ===== hdl/fpgs_checker.sv =====
// Port-level checks for the gain scheduler core, bound to the top level.
`default_nettype none

module fpgs_checker
  import fpgs_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    sample_valid,
  input wire logic    sample_ready,
  input wire sample_t sample,
  input wire logic    gain_valid,
  input wire logic    gain_ready,
  input wire gain_t   gain
);

  // Output item held while stalled
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    gain_valid && !gain_ready |=> gain_valid)
    else $error("gain item dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    gain_valid && !gain_ready |=> $stable(gain))
    else $error("gain payload changed while stalled");

  // Centroid stays inside the output singletons
  a_range: assert property (@(posedge clk) disable iff (rst)
    gain_valid |-> (gain.prop_gain_hundredths <= 6'd60)
                   && (gain.deriv_gain_hundredths <= 6'd40))
    else $error("gain outside output table range");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !gain_valid)
    else $error("gain_valid after reset");

endmodule

bind fuzzy_pd_gain_scheduler_core fpgs_checker u_fpgs_checker (.*);

`default_nettype wire

// ===== bench/fuzzy_pd_gain_scheduler_core_test.sv =====
// Self-checking testbench for the fuzzy P/D gain scheduler core.
`timescale 1ns / 100ps

module fuzzy_pd_gain_scheduler_core_test;
  import fpgs_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASE_ITEMS     = 540;

  // Local copies of the fixed breakpoints, rule tables and output singletons
  localparam int ERR_KNOT [7] = '{-180, -110, -50, 0, 50, 110, 180};
  localparam int CHG_KNOT [7] = '{-12, -8, -4, 0, 4, 8, 12};
  localparam int unsigned P_LEVEL [7] = '{0, 10, 20, 30, 40, 50, 60};
  localparam int unsigned D_LEVEL [7] = '{10, 20, 30, 40, 0, 0, 0};

  localparam logic [2:0] P_TABLE [7][7] = '{
    '{3'd6, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4},
    '{3'd5, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1},
    '{3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
    '{3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2},
    '{3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2},
    '{3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5},
    '{3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6}};

  localparam logic [2:0] D_TABLE [7][7] = '{
    '{3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3},
    '{3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3},
    '{3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd3, 3'd3},
    '{3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1},
    '{3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2},
    '{3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3},
    '{3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2}};

  logic    clk;
  logic    rst;
  logic    sample_valid;
  logic    sample_ready;
  sample_t sample;
  logic    gain_valid;
  logic    gain_ready;
  gain_t   gain;

  gain_t pending_gains [$];
  int    mismatch_count   = 0;
  int    send_idle_pct    = 0;
  int    recv_idle_pct    = 0;
  bit    hold_off_request = 1'b0;
  int    quiet_cycles     = 0;

  fuzzy_pd_gain_scheduler_core dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .gain_valid   (gain_valid),
    .gain_ready   (gain_ready),
    .gain         (gain)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Segment and lower-breakpoint membership of one input, clamped at both ends
  function automatic void place_on_knots(input int x, input int knot [7],
                                         output int unsigned seg,
                                         output int unsigned mu_low);
    bit found;
    found  = 1'b0;
    seg    = 5;
    mu_low = 0;
    if (x <= knot[0]) begin
      seg    = 0;
      mu_low = 100;
    end else if (x < knot[6]) begin
      for (int k = 0; k < 6; k++) begin
        if (!found && x <= knot[k+1]) begin
          found  = 1'b1;
          seg    = k;
          mu_low = (100 * (knot[k+1] - x)) / (knot[k+1] - knot[k]);
        end
      end
    end
  endfunction

  // Centroid over four cells; a shared rule value keeps only its larger weight
  function automatic logic [5:0] centroid(input logic [2:0] rule_val [4],
                                          input int unsigned weight_in [4],
                                          input bit deriv);
    int unsigned w [4];
    int unsigned num;
    int unsigned den;
    int unsigned level;
    w   = weight_in;
    num = 0;
    den = 0;
    for (int i = 0; i < 4; i++) begin
      for (int j = i + 1; j < 4; j++) begin
        if (rule_val[i] == rule_val[j]) begin
          if (w[i] > w[j]) w[j] = 0;
          else w[i] = 0;
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      level = deriv ? D_LEVEL[rule_val[i] % 7] : P_LEVEL[rule_val[i] % 7];
      num  += level * w[i];
      den  += w[i];
    end
    return (den != 0) ? 6'(num / den) : 6'd0;
  endfunction

  function automatic gain_t predict_gains(input sample_t s);
    int unsigned se, sc, pe0, pc0;
    int unsigned w [4];
    logic [2:0]  pr [4];
    logic [2:0]  dr [4];
    gain_t       g;
    place_on_knots(int'($signed(s.error)), ERR_KNOT, se, pe0);
    place_on_knots(int'($signed(s.error_change)), CHG_KNOT, sc, pc0);
    w[0] = (pe0 <= pc0) ? pe0 : pc0;
    w[1] = ((100 - pe0) <= pc0) ? (100 - pe0) : pc0;
    w[2] = (pe0 <= (100 - pc0)) ? pe0 : (100 - pc0);
    w[3] = ((100 - pe0) <= (100 - pc0)) ? (100 - pe0) : (100 - pc0);
    pr = '{P_TABLE[se][sc], P_TABLE[se+1][sc], P_TABLE[se][sc+1], P_TABLE[se+1][sc+1]};
    dr = '{D_TABLE[se][sc], D_TABLE[se+1][sc], D_TABLE[se][sc+1], D_TABLE[se+1][sc+1]};
    g.prop_gain_hundredths  = centroid(pr, w, 1'b0);
    g.deriv_gain_hundredths = centroid(dr, w, 1'b1);
    return g;
  endfunction

  function automatic sample_t make_sample(input int e, input int c);
    sample_t s;
    s.error        = 16'(e);
    s.error_change = 16'(c);
    return s;
  endfunction

  // Mostly values around the breakpoints, some across the full 16-bit range
  function automatic sample_t random_sample();
    int e, c;
    e = ($urandom_range(99) < 20) ? int'($urandom_range(65535)) - 32768
                                  : int'($urandom_range(420)) - 210;
    c = ($urandom_range(99) < 20) ? int'($urandom_range(65535)) - 32768
                                  : int'($urandom_range(32)) - 16;
    return make_sample(e, c);
  endfunction

  // Offer one item from a falling edge; returns on the falling edge after acceptance
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
    pending_gains.push_back(predict_gains(s));
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected gain has come out
  task automatic wait_for_drain();
    sample_valid <= 1'b0;
    while (pending_gains.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed_corners();
    int pts [23][2] = '{
      '{-32768, -32768}, '{32767, 32767}, '{-32768, 32767}, '{32767, -32768}, '{0, 0},
      '{-180, -12}, '{-110, -8}, '{-50, -4}, '{50, 4}, '{110, 8}, '{180, 12},
      '{-181, -13}, '{181, 13}, '{-179, -11}, '{179, 11},
      '{-145, -10}, '{-80, -6}, '{-25, -2}, '{25, 2}, '{80, 6}, '{145, 10},
      '{-1, 1}, '{1, -1}};
    send_idle_pct = 32;
    recv_idle_pct = 69;
    foreach (pts[i]) send_sample(make_sample(pts[i][0], pts[i][1]));
  endtask

  task automatic test_random_phase(input int n, input int s_idle, input int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) send_sample(random_sample());
  endtask

  // Output held off for a long stretch while items keep coming, so the pipe fills
  task automatic test_output_hold_off();
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    hold_off_request = 1'b1;
    repeat (40) send_sample(random_sample());
    wait_for_drain();
  endtask

  // Sender pauses until the pipe is empty, then resumes
  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_idle_pct = 20;
    repeat (20) send_sample(random_sample());
    wait_for_drain();
    repeat (20) send_sample(random_sample());
  endtask

  // Result side: random ready, or a counted hold-off when requested
  initial begin
    gain_ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_off_request) begin
        gain_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_request = 1'b0;
      end else begin
        gain_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted gain with the oldest prediction
  always @(posedge clk) begin
    gain_t expd;
    gain_t got;
    if (!rst && gain_valid && gain_ready) begin
      got = gain;
      if (pending_gains.size() == 0) begin
        $error("unexpected gain item: prop=%0d deriv=%0d",
               got.prop_gain_hundredths, got.deriv_gain_hundredths);
        mismatch_count++;
      end else begin
        expd = pending_gains.pop_front();
        if (got.prop_gain_hundredths !== expd.prop_gain_hundredths) begin
          $error("prop_gain_hundredths: expected %0d, got %0d",
                 expd.prop_gain_hundredths, got.prop_gain_hundredths);
          mismatch_count++;
        end
        if (got.deriv_gain_hundredths !== expd.deriv_gain_hundredths) begin
          $error("deriv_gain_hundredths: expected %0d, got %0d",
                 expd.deriv_gain_hundredths, got.deriv_gain_hundredths);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (gain_valid && gain_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("fuzzy_pd_gain_scheduler_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_corners();
    test_random_phase(PHASE_ITEMS, 32, 69);
    test_output_hold_off();
    test_random_phase(PHASE_ITEMS, 69, 32);
    test_drain_pause();
    test_random_phase(PHASE_ITEMS, 0, 0);

    // Let the pipe empty, then watch a little longer for stray items
    wait_for_drain();
    repeat (2 * NUM_STAGES + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("fuzzy_pd_gain_scheduler_core regression: pass");
    end else begin
      $display("fuzzy_pd_gain_scheduler_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fpgs_pkg.sv
hdl/fpgs_fuzzify.sv
hdl/fpgs_infer.sv
hdl/fpgs_divider.sv
hdl/fuzzy_pd_gain_scheduler_core.sv
hdl/fpgs_checker.sv
bench/fuzzy_pd_gain_scheduler_core_test.sv
